>>> hdl/ordered_list_insert_delete_defines.svh
// Assertion macros shared by the ordered list modules.
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OLI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OLI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/oli_pkg.sv
// Types, codes and constants of the ordered list block.
`timescale 1ns / 1ps

package oli_pkg;

    localparam int CAPACITY_DEF = 16;

    // operation codes
    localparam logic [2:0] FN_INS_FIRST = 3'd0;
    localparam logic [2:0] FN_INS_LAST  = 3'd1;
    localparam logic [2:0] FN_INS_AT    = 3'd2;
    localparam logic [2:0] FN_DEL_FIRST = 3'd3;
    localparam logic [2:0] FN_DEL_LAST  = 3'd4;
    localparam logic [2:0] FN_DEL_AT    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INS,
        OP_DEL
    } op_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REMOVE,
        S_SHIFT,
        S_FINISH,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic        [2:0]  func;
        logic signed [31:0] value;
        logic        [4:0]  index;
    } req_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic               removed_valid;
        logic signed [31:0] removed_value;
        logic signed [31:0] element_value;
        logic        [3:0]  element_position;
        logic               list_empty;
        logic        [4:0]  entry_count;
        logic               last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic rd_pos;
        logic shift;
        logic finish;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_kind_t   kind;
        logic [1:0] code;
        logic       shift_more;
        logic       emit_last;
    } sts_t;

endpackage

>>> hdl/ordered_list_insert_delete.sv
// Top level of the bounded ordered list: controller plus datapath with entry RAM.
// Sequence: an accepted op is checked; a rejected or unknown op goes to reporting,
//   an insert moves entries (one per cycle through the RAM) and then updates the count,
//   and a delete first reads the removed entry, then moves entries and updates the count.
//   Reporting emits max(count,1) results, one per cycle; result strobes cannot stall.
// Reset: rst_n clears the count and all control state; the RAM is not cleared.
`timescale 1ns / 1ps

module ordered_list_insert_delete #(
    parameter int CAPACITY = oli_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  oli_pkg::req_t req,
    output logic          result_valid,
    output oli_pkg::rsp_t result
);

    // command and status between the sequencer and the datapath
    oli_pkg::cmd_t cmd;
    oli_pkg::sts_t sts;

    // Sequencer: load the request on transfer, check it, move entries one per
    // cycle, update the count, then walk the list to report every entry.
    oli_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Datapath: hold the request, the count and the pointers; the entries live
    // in a RAM with registered read, and each result is shown for one cycle.
    oli_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> hdl/oli_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module oli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = oli_pkg::CAPACITY_DEF
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/oli_ctrl.sv
// Sequencing state machine of the ordered list block.
`timescale 1ns / 1ps
`include "ordered_list_insert_delete_defines.svh"

module oli_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  oli_pkg::sts_t sts,
    output oli_pkg::cmd_t cmd
);

    oli_pkg::ctrl_state_t state_reg;
    oli_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oli_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            oli_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                if (start)
                begin
                    state_next = oli_pkg::S_CHECK;
                end
            end
            oli_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.code != oli_pkg::ST_OK || sts.kind == oli_pkg::OP_NOP)
                begin
                    state_next = oli_pkg::S_EMIT;
                end
                else if (sts.kind == oli_pkg::OP_INS)
                begin
                    state_next = oli_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = oli_pkg::S_REMOVE;
                end
            end
            oli_pkg::S_REMOVE:
            begin
                cmd.rd_pos = 1'b1;
                state_next = oli_pkg::S_SHIFT;
            end
            oli_pkg::S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (!sts.shift_more)
                begin
                    state_next = oli_pkg::S_FINISH;
                end
            end
            oli_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = oli_pkg::S_EMIT;
            end
            oli_pkg::S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.emit_last)
                begin
                    state_next = oli_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oli_pkg::S_IDLE;
            end
        endcase
    end

    `OLI_ASSERT_NXT(a_accept_check, start && state_reg == oli_pkg::S_IDLE, state_reg == oli_pkg::S_CHECK, "accepted op did not enter check")
    `OLI_ASSERT_IMP(a_finish_drained, state_reg == oli_pkg::S_FINISH, !sts.shift_more, "finish entered with moves left")
    `OLI_ASSERT_IMP(a_busy_state, busy, state_reg != oli_pkg::S_IDLE, "busy while idle")

endmodule

>>> hdl/oli_dp.sv
// Datapath of the ordered list block: request, count, pointers, entry RAM, results.
`timescale 1ns / 1ps
`include "ordered_list_insert_delete_defines.svh"

module oli_dp #(
    parameter int CAPACITY = oli_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  oli_pkg::req_t req,
    input  oli_pkg::cmd_t cmd,
    output oli_pkg::sts_t sts,
    output logic          result_valid,
    output oli_pkg::rsp_t result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    // control registers
    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg, pend_next;
    logic          rm_pend_reg, rm_pend_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic        [2:0]    func_reg, func_next;
    logic signed [31:0]   value_reg, value_next;
    logic        [4:0]    index_reg, index_next;
    oli_pkg::op_kind_t    kind_reg, kind_next;
    logic        [1:0]    code_reg, code_next;
    logic                 rvalid_reg, rvalid_next;
    logic signed [31:0]   rval_reg, rval_next;
    logic        [CW-1:0] pos_reg, pos_next;
    logic        [CW-1:0] ptr_reg, ptr_next;
    logic        [AW-1:0] wr_addr_reg, wr_addr_next;
    logic        [CW-1:0] em_ptr_reg, em_ptr_next;
    logic        [AW-1:0] em_pos_reg, em_pos_next;
    logic                 em_last_reg, em_last_next;
    logic                 em_empty_reg, em_empty_next;

    // decode of the held request
    oli_pkg::op_kind_t kind_c;
    logic [1:0]        code_c;
    logic              rvalid_c;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     count_x;
    logic [XW-1:0]     idx_x;

    logic shift_more;
    logic emit_last;

    // entry RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    assign count_x = XW'(count_reg);
    assign idx_x   = XW'(index_reg);

    always_comb
    begin
        kind_c   = oli_pkg::OP_NOP;
        code_c   = oli_pkg::ST_OK;
        rvalid_c = 1'b0;
        pos_x    = '0;
        unique case (func_reg)
            oli_pkg::FN_INS_FIRST:
            begin
                kind_c = oli_pkg::OP_INS;
            end
            oli_pkg::FN_INS_LAST:
            begin
                kind_c = oli_pkg::OP_INS;
                pos_x  = count_x;
            end
            oli_pkg::FN_INS_AT:
            begin
                kind_c = oli_pkg::OP_INS;
                pos_x  = idx_x;
            end
            oli_pkg::FN_DEL_FIRST:
            begin
                kind_c = oli_pkg::OP_DEL;
            end
            oli_pkg::FN_DEL_LAST:
            begin
                kind_c = oli_pkg::OP_DEL;
                pos_x  = count_x - XW'(1);
            end
            oli_pkg::FN_DEL_AT:
            begin
                kind_c = oli_pkg::OP_DEL;
                pos_x  = idx_x;
            end
            default:
            begin
                kind_c = oli_pkg::OP_NOP;
            end
        endcase

        if (kind_c == oli_pkg::OP_INS)
        begin
            // index check ranks above the full check
            if (pos_x > count_x)
            begin
                code_c = oli_pkg::ST_INDEX;
            end
            else if (count_reg == CW'(CAPACITY))
            begin
                code_c = oli_pkg::ST_FULL;
            end
        end
        else if (kind_c == oli_pkg::OP_DEL)
        begin
            if (func_reg == oli_pkg::FN_DEL_AT)
            begin
                if (idx_x >= count_x)
                begin
                    code_c = oli_pkg::ST_INDEX;
                end
                else
                begin
                    rvalid_c = (index_reg == '0);
                end
            end
            else if (count_reg == '0)
            begin
                code_c = oli_pkg::ST_EMPTY;
            end
            else
            begin
                rvalid_c = 1'b1;
            end
        end
    end

    assign shift_more = (kind_reg == oli_pkg::OP_INS) ? (ptr_reg > pos_reg)
                                                      : (ptr_reg < count_reg);
    assign emit_last  = (count_reg == '0) || (em_ptr_reg == count_reg - CW'(1));

    assign sts.kind       = kind_c;
    assign sts.code       = code_c;
    assign sts.shift_more = shift_more;
    assign sts.emit_last  = emit_last;

    // RAM read port: removed entry, shift source, or entry to report
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = AW'(em_ptr_reg);
        priority if (cmd.rd_pos)
        begin
            ram_re    = 1'b1;
            ram_raddr = AW'(pos_reg);
        end
        else if (cmd.shift && shift_more)
        begin
            ram_re    = 1'b1;
            ram_raddr = (kind_reg == oli_pkg::OP_INS) ? AW'(ptr_reg - CW'(1)) : AW'(ptr_reg);
        end
        else if (cmd.emit && count_reg != '0)
        begin
            ram_re    = 1'b1;
            ram_raddr = AW'(em_ptr_reg);
        end
    end

    // RAM write port: land the entry read last cycle, or place the new value
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        priority if (pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.finish && kind_reg == oli_pkg::OP_INS)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(pos_reg);
            ram_wdata = value_reg;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        kind_next      = kind_reg;
        code_next      = code_reg;
        rvalid_next    = rvalid_reg;
        rval_next      = rval_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        wr_addr_next   = wr_addr_reg;
        em_ptr_next    = em_ptr_reg;
        em_pos_next    = em_pos_reg;
        em_last_next   = em_last_reg;
        em_empty_next  = em_empty_reg;
        pend_next      = cmd.shift && shift_more;
        rm_pend_next   = cmd.rd_pos;
        out_valid_next = cmd.emit;

        if (cmd.load)
        begin
            func_next  = req.func;
            value_next = req.value;
            index_next = req.index;
        end

        if (cmd.check)
        begin
            kind_next   = kind_c;
            code_next   = code_c;
            rvalid_next = rvalid_c;
            rval_next   = '0;
            pos_next    = CW'(pos_x);
            em_ptr_next = '0;
            ptr_next    = (kind_c == oli_pkg::OP_INS) ? count_reg : CW'(pos_x) + CW'(1);
        end

        if (rm_pend_reg)
        begin
            rval_next = rvalid_reg ? ram_rdata : '0;
        end

        if (cmd.shift && shift_more)
        begin
            if (kind_reg == oli_pkg::OP_INS)
            begin
                ptr_next     = ptr_reg - CW'(1);
                wr_addr_next = AW'(ptr_reg);
            end
            else
            begin
                ptr_next     = ptr_reg + CW'(1);
                wr_addr_next = AW'(ptr_reg - CW'(1));
            end
        end

        if (cmd.finish)
        begin
            count_next = (kind_reg == oli_pkg::OP_INS) ? count_reg + CW'(1)
                                                       : count_reg - CW'(1);
        end

        if (cmd.emit)
        begin
            em_ptr_next   = em_ptr_reg + CW'(1);
            em_pos_next   = AW'(em_ptr_reg);
            em_last_next  = emit_last;
            em_empty_next = (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rm_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rm_pend_reg   <= rm_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        value_reg    <= value_next;
        index_reg    <= index_next;
        kind_reg     <= kind_next;
        code_reg     <= code_next;
        rvalid_reg   <= rvalid_next;
        rval_reg     <= rval_next;
        pos_reg      <= pos_next;
        ptr_reg      <= ptr_next;
        wr_addr_reg  <= wr_addr_next;
        em_ptr_reg   <= em_ptr_next;
        em_pos_reg   <= em_pos_next;
        em_last_reg  <= em_last_next;
        em_empty_reg <= em_empty_next;
    end

    oli_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign result_valid            = out_valid_reg;
    assign result.status           = code_reg;
    assign result.removed_valid    = rvalid_reg;
    assign result.removed_value    = rval_reg;
    assign result.element_value    = em_empty_reg ? '0 : ram_rdata;
    assign result.element_position = 4'(em_pos_reg);
    assign result.list_empty       = em_empty_reg;
    assign result.entry_count      = 5'(count_reg);
    assign result.last             = em_last_reg;

    `OLI_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `OLI_ASSERT_IMP(a_no_write_clash, pend_reg, !(cmd.finish && kind_reg == oli_pkg::OP_INS), "shift write collides with value write")
    `OLI_ASSERT_IMP(a_empty_single, out_valid_reg && em_empty_reg, em_last_reg && count_reg == '0, "empty result not single and last")

endmodule

>>> dv/tb_ordered_list_insert_delete.sv
// Self-checking testbench for the bounded ordered list: command-style driver, result monitor.
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete;

    import oli_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;

    // func codes the block does not define; it must treat them as no-ops
    localparam logic [2:0] FN_UNUSED_6 = 3'd6;
    localparam logic [2:0] FN_UNUSED_7 = 3'd7;

    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_OPS  = 200;
    localparam int PHASE_LEN   = 40;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    req_t  req = '0;
    logic  result_valid;
    rsp_t  result;

    ordered_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result)
    );

    // 20 ns clock: low half, then high half
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Operations waiting to be sent; the initial block fills it, the monitor
    // drops the head once the block takes it.
    req_t op_queue[$];
    // List snapshots expected from the block, one entry per result strobe.
    rsp_t listing_q[$];

    // Shadow copy of the list contents used to predict every listing.
    logic signed [31:0] shadow_vals[CAPACITY];
    int                 shadow_len = 0;

    int mismatches = 0;
    int taken_cnt  = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Remove one entry from the shadow list, close the hole, return the value.
    function automatic logic signed [31:0] extract_entry(input int pos);
        logic signed [31:0] v;
        v = shadow_vals[pos];
        for (int k = pos; k + 1 < shadow_len; k++)
            shadow_vals[k] = shadow_vals[k + 1];
        shadow_len--;
        return v;
    endfunction

    // Apply one operation to the shadow list and queue the listing that must follow.
    task automatic apply_list_op(input req_t op);
        logic [1:0]         st;
        logic               rv;
        logic signed [31:0] rval;
        logic signed [31:0] tmp;
        int                 pos;
        rsp_t               snap;
        st   = ST_OK;
        rv   = 1'b0;
        rval = '0;
        case (op.func)
            FN_INS_FIRST, FN_INS_LAST, FN_INS_AT:
            begin
                pos = (op.func == FN_INS_FIRST) ? 0 :
                      (op.func == FN_INS_LAST)  ? shadow_len : int'(op.index);
                // index check wins over the full check
                if (pos > shadow_len)
                    st = ST_INDEX;
                else if (shadow_len >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (int k = shadow_len; k > pos; k--)
                        shadow_vals[k] = shadow_vals[k - 1];
                    shadow_vals[pos] = op.value;
                    shadow_len++;
                end
            end
            FN_DEL_FIRST, FN_DEL_LAST:
            begin
                if (shadow_len == 0)
                    st = ST_EMPTY;
                else
                begin
                    rval = extract_entry(op.func == FN_DEL_FIRST ? 0 : shadow_len - 1);
                    rv   = 1'b1;
                end
            end
            FN_DEL_AT:
            begin
                // on an empty list every index is out of range
                if (int'(op.index) >= shadow_len)
                    st = ST_INDEX;
                else
                begin
                    tmp = extract_entry(int'(op.index));
                    // delete at the head reports like a delete first
                    if (op.index == 0)
                    begin
                        rval = tmp;
                        rv   = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        snap               = '0;
        snap.status        = st;
        snap.removed_valid = rv;
        snap.removed_value = rval;
        snap.entry_count   = 5'(shadow_len);
        if (shadow_len == 0)
        begin
            // an empty list still answers with one marked result
            snap.list_empty = 1'b1;
            snap.last       = 1'b1;
            listing_q.push_back(snap);
        end
        else
        begin
            for (int k = 0; k < shadow_len; k++)
            begin
                snap.element_value    = shadow_vals[k];
                snap.element_position = 4'(k);
                snap.last             = (k + 1 == shadow_len);
                listing_q.push_back(snap);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge, check results before taking the
    // new transfer so its listing never races with older ones.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (listing_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected result: %p", $realtime, result);
                end
                else
                begin
                    want = listing_q.pop_front();
                    if (result.status           !== want.status           ||
                        result.removed_valid    !== want.removed_valid    ||
                        result.removed_value    !== want.removed_value    ||
                        result.element_value    !== want.element_value    ||
                        result.element_position !== want.element_position ||
                        result.list_empty       !== want.list_empty       ||
                        result.entry_count      !== want.entry_count      ||
                        result.last             !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("[%0t] result mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, result);
                    end
                end
            end

            // a transfer happens when start meets an idle block
            if (start && !busy)
            begin
                apply_list_op(req);
                void'(op_queue.pop_front());
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge. The sender works in bursts
    // of transfers separated by idle gaps; a zero gap gives back-to-back
    // commands, long gaps land on every phase of the block's work.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;
    int seen_taken = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (taken_cnt != seen_taken)
            begin
                seen_taken = taken_cnt;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (op_queue.size() > 0)
            begin
                start <= 1'b1;
                req   <= op_queue[0];
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Length of the list as the generator sees it; only the count matters
    // for steering indexes toward legal ranges.
    int gen_len = 0;

    task automatic push_op(input logic [2:0] f, input logic signed [31:0] v,
                           input logic [4:0] ix);
        req_t op;
        op.func  = f;
        op.value = v;
        op.index = ix;
        op_queue.push_back(op);
        case (f)
            FN_INS_FIRST, FN_INS_LAST:
                if (gen_len < CAPACITY) gen_len++;
            FN_INS_AT:
                if (int'(ix) <= gen_len && gen_len < CAPACITY) gen_len++;
            FN_DEL_FIRST, FN_DEL_LAST:
                if (gen_len > 0) gen_len--;
            FN_DEL_AT:
                if (int'(ix) < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [2:0] f;
        logic [4:0] ix;
        int         roll;
        int         wait_cycles;
        bit         filling;

        // directed: rejections on an empty list, no-ops, extremes, head/tail
        // reporting and the one-entry delete last
        push_op(FN_DEL_FIRST, 32'sd5, 5'd0);          // empty on delete
        push_op(FN_DEL_LAST,  32'sd5, 5'd0);
        push_op(FN_DEL_AT,    32'sd5, 5'd0);          // empty list -> out of index
        push_op(FN_INS_AT,    32'sd9, 5'd1);          // index past the count
        push_op(FN_INS_AT,    32'sd9, 5'd31);
        push_op(FN_UNUSED_6,  32'sd1, 5'd0);          // unknown op, list still shown
        push_op(FN_INS_FIRST, 32'sh7FFF_FFFF, 5'd0);
        push_op(FN_DEL_LAST,  32'sd0, 5'd0);          // one entry -> empty
        push_op(FN_INS_LAST,  32'sh8000_0000, 5'd0);
        push_op(FN_INS_FIRST, -32'sd1, 5'd0);
        push_op(FN_INS_AT,    32'sd0, 5'd1);
        push_op(FN_INS_AT,    32'sh5555_5555, 5'd3);  // insert at the count = append
        push_op(FN_INS_AT,    32'sh2AAA_AAAA, 5'd5);  // past the count
        push_op(FN_UNUSED_7,  32'sd2, 5'd31);
        push_op(FN_DEL_AT,    32'sd0, 5'd0);          // head delete reports the value
        push_op(FN_DEL_AT,    32'sd0, 5'd1);          // inner delete does not
        push_op(FN_DEL_AT,    32'sd0, 5'd2);          // index equal to count
        push_op(FN_DEL_FIRST, 32'sd0, 5'd0);
        push_op(FN_DEL_AT,    32'sd0, 5'd0);          // last entry via index 0
        push_op(FN_INS_LAST,  32'shAAAA_AAAA, 5'd0);

        // random: alternate fill-heavy and drain-heavy phases so the list
        // reaches both full and empty many times; most indexes stay legal
        filling = 1'b1;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % PHASE_LEN == 0 && n > 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                f = ($urandom_range(0, 1) == 0) ? FN_UNUSED_6 : FN_UNUSED_7;
            else if ((roll < 78) == filling)
                f = 3'($urandom_range(int'(FN_INS_FIRST), int'(FN_INS_AT)));
            else
                f = 3'($urandom_range(int'(FN_DEL_FIRST), int'(FN_DEL_AT)));

            if ($urandom_range(0, 3) == 0)
                ix = 5'($urandom_range(0, 31));
            else if (f == FN_DEL_AT)
                ix = (gen_len > 0) ? 5'($urandom_range(0, gen_len - 1)) : 5'd0;
            else
                ix = 5'($urandom_range(0, gen_len));
            push_op(f, pick_value(), ix);
        end

        // hold reset, then release it between edges
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: everything sent and every listing seen
        while (op_queue.size() > 0 || listing_q.size() > 0)
            @(negedge clk);

        // let any stray strobes show up
        wait_cycles = 2 * (4 + 2 * CAPACITY);
        repeat (wait_cycles) @(negedge clk);

        if (mismatches == 0 && listing_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
